/* rtl/core/amgs_pkg.sv */
// shared constants, codes and types of the adjacency matrix graph store
package amgs_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int VERTEX_BITS  = $clog2(MAX_VERTICES);
  localparam int ADDR_BITS    = 2 * VERTEX_BITS;
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);
  localparam int LIM_BITS     = VERTEX_BITS + 1;

  // field widths of the stream items
  localparam int OP_BITS        = 2;
  localparam int ID_BITS        = 4;
  localparam int IN_WEIGHT_BITS = 16;
  localparam int TOTAL_BITS     = 5;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 5;
  localparam int LIMIT_BITS     = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTED = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT    = 1'd1;

  localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_EDGE   = 2'd2;

  typedef enum logic [1:0] {
    STATUS_DONE,
    STATUS_SAME,
    STATUS_ERROR
  } status_t;

  // op, the first field of the stream item, sits in the lowest bits
  typedef struct packed {
    logic [IN_WEIGHT_BITS-1:0] weight;
    logic [ID_BITS-1:0]        vertex_b;
    logic [ID_BITS-1:0]        vertex_a;
    logic [OP_BITS-1:0]        op;
  } item_t;

  typedef struct packed {
    logic                  graph_empty;
    logic [TOTAL_BITS-1:0] vertex_total;
    status_t               status;
  } result_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_BITS-1:0]   waddr;
    logic [WEIGHT_BITS-1:0] wdata;
    logic                   re;
    logic [ADDR_BITS-1:0]   raddr;
  } ram_req_t;

  localparam int S_TDATA_BITS = (($bits(item_t) + 7) / 8) * 8;
  localparam int M_TDATA_BITS = (($bits(result_t) + 7) / 8) * 8;

endpackage

/* rtl/core/adjacency_matrix_graph_store.sv */
// top level of the adjacency matrix graph store
//
// Requests enter on the s_ group (op, vertex_a, vertex_b, edge_weight) and
// each request gives exactly one result on the m_ group (status, vertex
// count, empty flag). Configuration (directed mode, vertex limit) is written
// through cfg_valid/cfg_index/cfg_data; cfg_ready is always high and writes
// take effect at once, so they belong between requests.
// One request is worked on at a time; the weight matrix sits in a single
// synchronous RAM with one write and one read port, and that port sets
// the steps from accept to m_tvalid:
//   add vertex, unknown op, no-change remove, bad ID, unused source: check
//   set edge to an unused destination: check, destination check
//   set edge: check, destination check with read, compare and write if new,
//     then a mirror write when undirected and the weight changed
//   remove vertex: check, then a sweep of one matrix entry per cycle
//     for its row and column
// Every request then passes through done, res_valid and m_tvalid; s_tready
// comes back in the cycle before m_tvalid rises.
// After reset the matrix is swept to zero, all MAX_VERTICES^2 entries (256),
// with s_tready low; configuration writes are taken during the sweep.
// A stalled m_tready holds the result in the output register; a finished
// request then waits before issuing its result and takes no new one.
module adjacency_matrix_graph_store (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // op[1:0], vertex_a[5:2], vertex_b[9:6], edge_weight[25:10], zero pad
  input  logic [amgs_pkg::S_TDATA_BITS-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // status[1:0], vertex_total[6:2], graph_empty[7]
  output logic [amgs_pkg::M_TDATA_BITS-1:0]     m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [amgs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [amgs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import amgs_pkg::*;

  item_t                  s_item;
  ram_req_t               ram_req;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic                   out_free;
  logic                   res_valid;
  result_t                res;
  result_t                out_reg;

  assign s_item    = s_tdata[$bits(item_t)-1:0];
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = M_TDATA_BITS'(out_reg);

  amgs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_item    (s_item),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  amgs_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res;
    end
  end

endmodule

/* rtl/core/amgs_ram.sv */
// weight matrix storage: one write port, one read port with registered data
module amgs_ram (
  input  logic                                clk,
  input  amgs_pkg::ram_req_t                  req,
  output logic [amgs_pkg::WEIGHT_BITS-1:0]    rdata
);
  import amgs_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* rtl/core/amgs_seq.sv */
// operation sequencer: vertex flags, count, config registers and matrix access
module amgs_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  amgs_pkg::item_t                       s_item,
  input  logic                                  s_valid,
  output logic                                  s_ready,
  input  logic                                  cfg_valid,
  input  logic [amgs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [amgs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output amgs_pkg::ram_req_t                    ram_req,
  input  logic [amgs_pkg::WEIGHT_BITS-1:0]      ram_rdata,
  input  logic                                  out_free,
  output logic                                  res_valid,
  output amgs_pkg::result_t                     res
);
  import amgs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_CHECK_B,
    ST_COMPARE,
    ST_MIRROR,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t                  state;
  item_t                   item;
  logic [ADDR_BITS-1:0]    cnt;
  logic [MAX_VERTICES-1:0] vertex_used;
  logic [COUNT_BITS-1:0]   used_count;
  status_t                 status;
  logic                    directed;
  logic [LIMIT_BITS-1:0]   limit;

  logic [LIM_BITS-1:0]    eff_lim;
  logic [VERTEX_BITS-1:0] a_idx;
  logic [VERTEX_BITS-1:0] b_idx;
  logic [VERTEX_BITS-1:0] used_sel;
  logic [VERTEX_BITS-1:0] sweep_i;
  logic                   used_bit;
  logic                   a_bad;
  logic                   b_bad;
  logic                   sweep_last;
  logic [WEIGHT_BITS-1:0] weight;

  always_comb begin
    if (limit == '0) begin
      eff_lim = LIM_BITS'(1);
    end else if (int'(limit) > MAX_VERTICES) begin
      eff_lim = LIM_BITS'(MAX_VERTICES);
    end else begin
      eff_lim = LIM_BITS'(limit);
    end
  end

  assign a_idx      = VERTEX_BITS'(item.vertex_a);
  assign b_idx      = VERTEX_BITS'(item.vertex_b);
  assign a_bad      = item.vertex_a >= eff_lim;
  assign b_bad      = item.vertex_b >= eff_lim;
  // one flag lookup a cycle: source first, destination in its own step
  assign used_sel   = (state == ST_CHECK_B) ? b_idx : a_idx;
  assign used_bit   = vertex_used[used_sel];
  assign weight     = WEIGHT_BITS'($signed(item.weight));
  // sweep alternates row entry and column entry of the removed vertex
  assign sweep_i    = cnt[VERTEX_BITS:1];
  assign sweep_last = &cnt[VERTEX_BITS:0];
  assign s_ready    = (state == ST_IDLE);

  always_comb begin
    ram_req = '0;
    case (state)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt;
      end
      ST_CHECK_B: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = {a_idx, b_idx};
      end
      ST_COMPARE: begin
        ram_req.we    = (ram_rdata != weight);
        ram_req.waddr = {a_idx, b_idx};
        ram_req.wdata = weight;
      end
      ST_MIRROR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = {b_idx, a_idx};
        ram_req.wdata = weight;
      end
      ST_SWEEP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt[0] ? {sweep_i, a_idx} : {a_idx, sweep_i};
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_comb begin
    res.status       = status;
    res.vertex_total = TOTAL_BITS'(used_count);
    res.graph_empty  = (used_count == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      vertex_used <= '0;
      used_count  <= '0;
      directed    <= 1'b0;
      limit       <= LIMIT_RESET;
      res_valid   <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DIRECTED: directed <= cfg_data[0];
          CFG_LIMIT:    limit    <= cfg_data[LIMIT_BITS-1:0];
          default:      ;
        endcase
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (&cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_valid) begin
            item  <= s_item;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= ST_DONE;
          case (item.op)
            OP_ADD: begin
              if (a_bad) begin
                status <= STATUS_ERROR;
              end else if (used_bit) begin
                status <= STATUS_SAME;
              end else begin
                vertex_used[a_idx] <= 1'b1;
                used_count         <= used_count + 1'b1;
                status             <= STATUS_DONE;
              end
            end
            OP_REMOVE: begin
              if (a_bad) begin
                status <= STATUS_ERROR;
              end else if (!used_bit) begin
                status <= STATUS_SAME;
              end else begin
                cnt   <= '0;
                state <= ST_SWEEP;
              end
            end
            OP_EDGE: begin
              if (a_bad || b_bad || !used_bit) begin
                status <= STATUS_ERROR;
              end else begin
                state <= ST_CHECK_B;
              end
            end
            default: begin
              status <= STATUS_ERROR;
            end
          endcase
        end
        ST_CHECK_B: begin
          if (!used_bit) begin
            status <= STATUS_ERROR;
            state  <= ST_DONE;
          end else begin
            state <= ST_COMPARE;
          end
        end
        ST_COMPARE: begin
          if (ram_rdata == weight) begin
            status <= STATUS_SAME;
            state  <= ST_DONE;
          end else begin
            status <= STATUS_DONE;
            state  <= directed ? ST_DONE : ST_MIRROR;
          end
        end
        ST_MIRROR: begin
          state <= ST_DONE;
        end
        ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (sweep_last) begin
            vertex_used[a_idx] <= 1'b0;
            used_count         <= used_count - 1'b1;
            status             <= STATUS_DONE;
            state              <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    int'(used_count) == $countones(vertex_used))
    else $error("vertex count differs from used flags");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state == ST_CLEAR || state == ST_COMPARE ||
                    state == ST_MIRROR || state == ST_SWEEP))
    else $error("matrix write outside a writing step");

  a_mirror_undirected: assert property (@(posedge clk) disable iff (rst)
    state == ST_MIRROR |-> (!directed && $past(state) == ST_COMPARE))
    else $error("mirror write without an undirected forward write");

  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(out_free))
    else $error("result issued while output register busy");

endmodule

/* dv/tb_adjacency_matrix_graph_store.sv */
// testbench of the adjacency matrix graph store: directed and random requests
`timescale 1ns / 1ps

module tb_adjacency_matrix_graph_store;
  import amgs_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNKNOWN = 2'd3;
  localparam int REMOVE_CYCLES = 2 * MAX_VERTICES + 3;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  adjacency_matrix_graph_store dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted graph state and settings
  bit directed_cfg = 1'b0;
  logic [LIMIT_BITS-1:0] limit_cfg = LIMIT_RESET;
  bit vtx_used [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] adj_weight [MAX_VERTICES][MAX_VERTICES];
  int vtx_count = 0;

  result_t replies_due [$];
  int error_count = 0;
  int unsigned max_gap = 10;
  int unsigned max_stall = 10;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_limit();
    if (limit_cfg == 0) return 1;
    if (int'(limit_cfg) > MAX_VERTICES) return MAX_VERTICES;
    return 32'(limit_cfg);
  endfunction

  function automatic result_t apply_graph_op(input item_t it);
    result_t res;
    int unsigned lim;
    logic [ID_BITS-1:0] a;
    logic [ID_BITS-1:0] b;
    lim = active_limit();
    a = it.vertex_a;
    b = it.vertex_b;
    case (it.op)
      OP_ADD: begin
        if (a >= lim) res.status = STATUS_ERROR;
        else if (vtx_used[a]) res.status = STATUS_SAME;
        else begin
          vtx_used[a] = 1'b1;
          vtx_count++;
          res.status = STATUS_DONE;
        end
      end
      OP_REMOVE: begin
        if (a >= lim) res.status = STATUS_ERROR;
        else if (!vtx_used[a]) res.status = STATUS_SAME;
        else begin
          for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_weight[VERTEX_BITS'(i)][a] = '0;
            adj_weight[a][VERTEX_BITS'(i)] = '0;
          end
          vtx_used[a] = 1'b0;
          if (vtx_count > 0) vtx_count--;
          res.status = STATUS_DONE;
        end
      end
      OP_EDGE: begin
        if (a >= lim || b >= lim) res.status = STATUS_ERROR;
        else if (!vtx_used[a] || !vtx_used[b]) res.status = STATUS_ERROR;
        // only the forward entry decides a repeated write
        else if (adj_weight[a][b] == it.weight) res.status = STATUS_SAME;
        else begin
          adj_weight[a][b] = it.weight;
          if (!directed_cfg) adj_weight[b][a] = it.weight;
          res.status = STATUS_DONE;
        end
      end
      default: res.status = STATUS_ERROR;
    endcase
    res.vertex_total = vtx_count[TOTAL_BITS-1:0];
    res.graph_empty = (vtx_count == 0);
    return res;
  endfunction

  // random request, mostly aimed at vertices that are in range and in use
  function automatic item_t draw_graph_op();
    item_t it;
    int unsigned lim;
    int unsigned pick;
    int used_ids [$];
    lim = active_limit();
    for (int v = 0; v < MAX_VERTICES; v++)
      if (vtx_used[VERTEX_BITS'(v)] && v < lim) used_ids.push_back(v);
    it.op = OP_UNKNOWN;
    it.vertex_a = ID_BITS'($urandom_range(MAX_VERTICES - 1, 0));
    it.vertex_b = ID_BITS'($urandom_range(MAX_VERTICES - 1, 0));
    it.weight = IN_WEIGHT_BITS'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 25) begin
      it.op = OP_ADD;
      if ($urandom_range(9, 0) != 0) it.vertex_a = ID_BITS'($urandom_range(lim - 1, 0));
    end else if (pick < 37) begin
      it.op = OP_REMOVE;
      if (used_ids.size() != 0 && $urandom_range(1, 0) == 1)
        it.vertex_a = ID_BITS'(used_ids[$urandom_range(used_ids.size() - 1, 0)]);
      else if ($urandom_range(9, 0) != 0)
        it.vertex_a = ID_BITS'($urandom_range(lim - 1, 0));
    end else if (pick < 95) begin
      it.op = OP_EDGE;
      if (used_ids.size() != 0 && $urandom_range(9, 0) != 0) begin
        it.vertex_a = ID_BITS'(used_ids[$urandom_range(used_ids.size() - 1, 0)]);
        it.vertex_b = ID_BITS'(used_ids[$urandom_range(used_ids.size() - 1, 0)]);
      end
      case ($urandom_range(7, 0))
        0: it.weight = '0;
        1: it.weight = adj_weight[it.vertex_a][it.vertex_b];
        2: it.weight = $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_op(input item_t it);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_TDATA_BITS - $bits(item_t)){1'b0}}, it};
    do @(posedge clk); while (!s_tready);
    replies_due.push_back(apply_graph_op(it));
  endtask

  task automatic send_fields(input logic [OP_BITS-1:0] op, input int a, input int b,
                             input logic [IN_WEIGHT_BITS-1:0] w);
    item_t it;
    it.op = op;
    it.vertex_a = ID_BITS'(a);
    it.vertex_b = ID_BITS'(b);
    it.weight = w;
    send_op(it);
  endtask

  // settings change only once every request has its result
  task automatic configure(input bit dir, input logic [LIMIT_BITS-1:0] lim);
    logic [CFG_DATA_BITS-1:0] dir_word;
    dir_word = {4'($urandom), dir};
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DIRECTED;
    cfg_data <= dir_word;
    do @(posedge clk); while (!cfg_ready);
    directed_cfg = dir_word[0];
    cfg_index <= CFG_LIMIT;
    cfg_data <= lim;
    do @(posedge clk); while (!cfg_ready);
    limit_cfg = lim;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_vertex_ops();
    configure(1'b0, 5'd16);
    send_fields(OP_REMOVE, 3, 0, 16'h0000);
    send_fields(OP_ADD, 0, 0, 16'h0000);
    send_fields(OP_ADD, 0, 15, 16'hffff);
    send_fields(OP_ADD, 15, 0, 16'h0000);
    send_fields(OP_ADD, 5, 0, 16'h0000);
    send_fields(OP_UNKNOWN, 15, 15, 16'hffff);
  endtask

  task automatic test_edge_ops();
    send_fields(OP_EDGE, 0, 3, 16'h1234);
    send_fields(OP_EDGE, 0, 15, 16'h7fff);
    send_fields(OP_EDGE, 0, 15, 16'h7fff);
    send_fields(OP_EDGE, 15, 0, 16'h8000);
    configure(1'b1, 5'd16);
    send_fields(OP_EDGE, 5, 0, 16'hffff);
    send_fields(OP_EDGE, 0, 5, 16'h0001);
    send_fields(OP_EDGE, 0, 5, 16'h0000);
    send_fields(OP_EDGE, 5, 5, 16'h0000);
    send_fields(OP_REMOVE, 0, 0, 16'h0000);
  endtask

  task automatic test_vertex_limit();
    configure(1'b1, 5'd4);
    send_fields(OP_ADD, 7, 0, 16'h0000);
    send_fields(OP_EDGE, 5, 15, 16'h0042);
    send_fields(OP_REMOVE, 15, 0, 16'h0000);
    send_fields(OP_ADD, 3, 0, 16'h0000);
    // zero limit behaves as one
    configure(1'b0, 5'd0);
    send_fields(OP_ADD, 0, 0, 16'h0000);
    send_fields(OP_ADD, 1, 0, 16'h0000);
    // limit above the vertex count clamps to the maximum
    configure(1'b1, 5'd31);
    send_fields(OP_REMOVE, 15, 0, 16'h0000);
    send_fields(OP_REMOVE, 5, 0, 16'h0000);
    send_fields(OP_REMOVE, 3, 0, 16'h0000);
    send_fields(OP_REMOVE, 0, 0, 16'h0000);
  endtask

  task automatic test_random_mix(input int per_phase);
    bit dir;
    logic [LIMIT_BITS-1:0] lim;
    for (int p = 0; p < 6; p++) begin
      dir = p[0];
      case (p)
        0: begin lim = 5'd16; max_gap = 10; max_stall = 10; end
        1: begin lim = 5'd16; max_gap = 0;  max_stall = 0;  end
        2: begin lim = 5'd9;  max_gap = 10; max_stall = 0;  end
        3: begin lim = 5'd1;  max_gap = 0;  max_stall = 10; end
        4: begin lim = 5'd5;  max_gap = 10; max_stall = 10; end
        default: begin lim = 5'd31; max_gap = 3; max_stall = 10; end
      endcase
      configure(dir, lim);
      repeat (per_phase) send_op(draw_graph_op());
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    clk = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      vtx_used[VERTEX_BITS'(i)] = 1'b0;
      for (int j = 0; j < MAX_VERTICES; j++)
        adj_weight[VERTEX_BITS'(i)][VERTEX_BITS'(j)] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_vertex_ops();
    test_edge_ops();
    test_vertex_limit();
    test_random_mix(250);
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (REMOVE_CYCLES + 5) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // result side backpressure
  initial begin
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(max_stall, 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (replies_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result with no request pending: status %0d total %0d empty %0b",
                   $realtime, got.status, got.vertex_total, got.graph_empty);
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status || got.vertex_total !== want.vertex_total ||
            got.graph_empty !== want.graph_empty) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch: status %0d/%0d total %0d/%0d empty %0b/%0b (exp/act)",
                     $realtime, want.status, got.status, want.vertex_total,
                     got.vertex_total, want.graph_empty, got.graph_empty);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
